FILE: design/rtrf_pkg.sv
package rtrf_pkg;

  // Geometry of the register file
  localparam int REG_COUNT = 16;
  localparam int IDX_W     = 5;
  localparam int TAG_W     = 5;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Input request
  typedef struct packed {
    logic [IDX_W-1:0]  first_source_index;
    logic [IDX_W-1:0]  second_source_index;
    logic              issue_tag_write;
    logic [IDX_W-1:0]  issue_dest_index;
    logic [TAG_W-1:0]  issue_rob_tag;
    logic              commit_write;
    logic [IDX_W-1:0]  commit_dest_index;
    logic [DATA_W-1:0] commit_value;
    logic [TAG_W-1:0]  commit_rob_tag;
    logic              flush;
  } rtrf_in_t;

  // Result request
  typedef struct packed {
    logic [DATA_W-1:0] first_value;
    logic [TAG_W-1:0]  first_tag;
    logic              first_tag_valid;
    logic [DATA_W-1:0] second_value;
    logic [TAG_W-1:0]  second_tag;
    logic              second_tag_valid;
  } rtrf_out_t;

  // Read data of one storage port
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [TAG_W-1:0]  tag;
    logic              tag_valid;
  } rtrf_rd_t;

  // Update issued to the storage
  typedef struct packed {
    logic              en;
    logic              flush;
    logic              commit_en;
    logic              commit_clr;
    logic [ADDR_W-1:0] commit_addr;
    logic [DATA_W-1:0] commit_value;
    logic              issue_en;
    logic [ADDR_W-1:0] issue_addr;
    logic [TAG_W-1:0]  issue_tag;
  } rtrf_wr_t;

  // True when a register index names an existing register
  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    in_range = ({1'b0, idx} < (IDX_W+1)'(REG_COUNT));
  endfunction

endpackage

FILE: design/rtrf_in_if.sv
interface rtrf_in_if;
  logic                 valid;
  logic                 ready;
  rtrf_pkg::rtrf_in_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/rtrf_out_if.sv
interface rtrf_out_if;
  logic                 valid;
  logic                 ready;
  rtrf_pkg::rtrf_out_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/rtrf_store.sv
module rtrf_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [rtrf_pkg::ADDR_W-1:0]     rd_addr_a,
  input  logic [rtrf_pkg::ADDR_W-1:0]     rd_addr_b,
  output rtrf_pkg::rtrf_rd_t              rd_a,
  output rtrf_pkg::rtrf_rd_t              rd_b,
  input  rtrf_pkg::rtrf_wr_t              wr
);

  logic [rtrf_pkg::DATA_W-1:0] val_mem [rtrf_pkg::REG_COUNT];
  logic [rtrf_pkg::TAG_W-1:0]  tag_mem [rtrf_pkg::REG_COUNT];

  // Tag valid bits and value-written bits live in flops
  logic [rtrf_pkg::REG_COUNT-1:0] vld_r, vld_nxt;
  logic [rtrf_pkg::REG_COUNT-1:0] wrk_r, wrk_nxt;

  logic [rtrf_pkg::DATA_W-1:0] val_a_r, val_b_r;
  logic [rtrf_pkg::TAG_W-1:0]  tag_a_r, tag_b_r;
  logic                        vld_a_r, vld_b_r;
  logic                        wrk_a_r, wrk_b_r;

  // Compute next flag state: flush drops all tags; otherwise commit may release, issue claims
  always_comb begin
    vld_nxt = vld_r;
    wrk_nxt = wrk_r;
    if (wr.en) begin
      if (wr.flush) begin
        vld_nxt = '0;
      end else begin
        if (wr.commit_en) begin
          wrk_nxt[wr.commit_addr] = 1'b1;
          if (wr.commit_clr) vld_nxt[wr.commit_addr] = 1'b0;
        end
        if (wr.issue_en) vld_nxt[wr.issue_addr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      wrk_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      wrk_r <= wrk_nxt;
    end
  end

  // Write and read the memories; read data is registered
  always_ff @(posedge clk) begin
    if (wr.en && !wr.flush && wr.commit_en) val_mem[wr.commit_addr] <= wr.commit_value;
    if (wr.en && !wr.flush && wr.issue_en)  tag_mem[wr.issue_addr]  <= wr.issue_tag;
    if (rd_en) begin
      val_a_r <= val_mem[rd_addr_a];
      val_b_r <= val_mem[rd_addr_b];
      tag_a_r <= tag_mem[rd_addr_a];
      tag_b_r <= tag_mem[rd_addr_b];
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
      wrk_a_r <= wrk_r[rd_addr_a];
      wrk_b_r <= wrk_r[rd_addr_b];
    end
  end

  // Unwritten value entries read as zero
  assign rd_a.value     = wrk_a_r ? val_a_r : '0;
  assign rd_a.tag       = tag_a_r;
  assign rd_a.tag_valid = vld_a_r;
  assign rd_b.value     = wrk_b_r ? val_b_r : '0;
  assign rd_b.tag       = tag_b_r;
  assign rd_b.tag_valid = vld_b_r;

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $past(wr.en && wr.flush) |-> vld_r == '0)
    else $error("tag valid bits survive a flush");

  a_issue_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && !wr.flush && wr.issue_en) |=> vld_r[$past(wr.issue_addr)])
    else $error("issue did not set the tag valid bit");

  a_commit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && !wr.flush && wr.commit_en) |=> wrk_r[$past(wr.commit_addr)])
    else $error("commit did not mark the value entry written");

endmodule

FILE: design/rename_tag_register_file.sv
// A request's result passes through the registered reads, the result register
// and the output register. A new request is accepted only when idle with no
// result pending; then read sources, read the commit destination's tag from
// the same memory port, write back. Reset (synchronous, rst_n low): values,
// tags and tag valid bits all read as zero; no request or result is pending.
module rename_tag_register_file (
  input  logic         clk,
  input  logic         rst_n,
  rtrf_in_if.sink      in_ch,
  rtrf_out_if.source   out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WB} st_t;

  st_t                  st_r;
  rtrf_pkg::rtrf_in_t   req_r;
  rtrf_pkg::rtrf_out_t  res_r, res_nxt;
  logic                 res_pend_r;
  rtrf_pkg::rtrf_out_t  out_r;
  logic                 out_valid_r;

  logic                              in_acc;
  logic                              rd_en;
  logic [rtrf_pkg::ADDR_W-1:0]       rd_addr_a, rd_addr_b;
  rtrf_pkg::rtrf_rd_t                rd_a, rd_b;
  rtrf_pkg::rtrf_wr_t                wr;

  assign in_ch.ready    = (st_r == ST_IDLE) && !res_pend_r;
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  rtrf_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .wr        (wr)
  );

  // Select read addresses: sources at accept, commit destination after
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = in_ch.payload.first_source_index[rtrf_pkg::ADDR_W-1:0];
    rd_addr_b = in_ch.payload.second_source_index[rtrf_pkg::ADDR_W-1:0];
    if (st_r == ST_IDLE) begin
      rd_en = in_acc;
    end else if (st_r == ST_RD) begin
      rd_en     = 1'b1;
      rd_addr_a = req_r.commit_dest_index[rtrf_pkg::ADDR_W-1:0];
    end
  end

  // Form the result from the source reads
  always_comb begin
    res_nxt = '0;
    if (rtrf_pkg::in_range(req_r.first_source_index)) begin
      if (rd_a.tag_valid) begin
        res_nxt.first_tag       = rd_a.tag;
        res_nxt.first_tag_valid = 1'b1;
      end else begin
        res_nxt.first_value = rd_a.value;
      end
    end
    if (rtrf_pkg::in_range(req_r.second_source_index)) begin
      if (rd_b.tag_valid) begin
        res_nxt.second_tag       = rd_b.tag;
        res_nxt.second_tag_valid = 1'b1;
      end else begin
        res_nxt.second_value = rd_b.value;
      end
    end
  end

  // Build the write-back: commit releases a matching tag, issue wins afterwards
  always_comb begin
    wr              = '0;
    wr.en           = (st_r == ST_WB);
    wr.flush        = req_r.flush;
    wr.commit_en    = req_r.commit_write && rtrf_pkg::in_range(req_r.commit_dest_index);
    wr.commit_clr   = rd_a.tag_valid && (rd_a.tag == req_r.commit_rob_tag);
    wr.commit_addr  = req_r.commit_dest_index[rtrf_pkg::ADDR_W-1:0];
    wr.commit_value = req_r.commit_value;
    wr.issue_en     = req_r.issue_tag_write && rtrf_pkg::in_range(req_r.issue_dest_index);
    wr.issue_addr   = req_r.issue_dest_index[rtrf_pkg::ADDR_W-1:0];
    wr.issue_tag    = req_r.issue_rob_tag;
  end

  // Advance the sequencer and hold the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_pend_r && (!out_valid_r || out_ch.ready)) begin
        out_r       <= res_r;
        out_valid_r <= 1'b1;
        res_pend_r  <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r <= in_ch.payload;
            st_r  <= ST_RD;
          end
        end
        ST_RD: begin
          res_r      <= res_nxt;
          res_pend_r <= 1'b1;
          st_r       <= ST_WB;
        end
        ST_WB: begin
          st_r <= ST_IDLE;
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_rd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD) |-> $past(in_ch.valid && in_ch.ready))
    else $error("read stage entered without an accepted request");

  a_out_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_pend_r))
    else $error("result offered without a pending result");

  a_renamed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_r.first_tag_valid || out_r.first_value == '0) &&
                     (!out_r.second_tag_valid || out_r.second_value == '0)))
    else $error("renamed register returned a nonzero value");

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rtrf_pkg::*;

  localparam int HOLD_CYCLES      = 200;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int SETTLE_CYCLES    = 10;
  localparam int MAX_OPEN_RENAMES = 8;

  typedef struct {
    rtrf_in_t  req;
    bit        pinned;
    rtrf_out_t res;
  } dir_row_t;

  typedef struct {
    logic [IDX_W-1:0] dest;
    logic [TAG_W-1:0] tag;
  } rename_t;

  logic clk;
  logic rst_n;

  rtrf_in_if  in_ch ();
  rtrf_out_if out_ch ();

  rename_tag_register_file i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the register status table
  logic [DATA_W-1:0] shadow_value [REG_COUNT];
  logic [TAG_W-1:0]  shadow_tag   [REG_COUNT];
  logic              shadow_busy  [REG_COUNT];

  rtrf_out_t expected_reads [$];
  rename_t   open_renames   [$];
  dir_row_t  dir_table      [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_req_cnt   = 0;
  int hold_done_cnt  = 0;

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Read one port of the shadow table
  function automatic rtrf_rd_t lookup_port(logic [IDX_W-1:0] idx);
    rtrf_rd_t          rd;
    logic [ADDR_W-1:0] a;
    rd = '0;
    a  = idx[ADDR_W-1:0];
    if (int'(idx) < REG_COUNT) begin
      if (shadow_busy[a]) begin
        rd.tag       = shadow_tag[a];
        rd.tag_valid = 1'b1;
      end else begin
        rd.value = shadow_value[a];
      end
    end
    return rd;
  endfunction

  // Read both sources, then apply flush, or else commit and issue in that order
  function automatic rtrf_out_t advance_status_table(rtrf_in_t r);
    rtrf_out_t         res;
    logic [ADDR_W-1:0] cdst;
    logic [ADDR_W-1:0] idst;
    cdst = r.commit_dest_index[ADDR_W-1:0];
    idst = r.issue_dest_index[ADDR_W-1:0];
    res = rtrf_out_t'({lookup_port(r.first_source_index),
                       lookup_port(r.second_source_index)});
    if (r.flush) begin
      foreach (shadow_busy[i]) shadow_busy[i] = 1'b0;
      return res;
    end
    if (r.commit_write && int'(r.commit_dest_index) < REG_COUNT) begin
      shadow_value[cdst] = r.commit_value;
      // only the matching reorder entry releases the register
      if (shadow_busy[cdst] && shadow_tag[cdst] == r.commit_rob_tag)
        shadow_busy[cdst] = 1'b0;
    end
    if (r.issue_tag_write && int'(r.issue_dest_index) < REG_COUNT) begin
      shadow_tag[idst]  = r.issue_rob_tag;
      shadow_busy[idst] = 1'b1;
    end
    return res;
  endfunction

  function automatic rtrf_in_t mk_req(
    input int fs, input int ss,
    input bit iw, input int idst, input int itag,
    input bit cw, input int cdst, input logic [DATA_W-1:0] cval, input int ctag,
    input bit fl
  );
    rtrf_in_t r;
    r.first_source_index  = IDX_W'(fs);
    r.second_source_index = IDX_W'(ss);
    r.issue_tag_write     = iw;
    r.issue_dest_index    = IDX_W'(idst);
    r.issue_rob_tag       = TAG_W'(itag);
    r.commit_write        = cw;
    r.commit_dest_index   = IDX_W'(cdst);
    r.commit_value        = cval;
    r.commit_rob_tag      = TAG_W'(ctag);
    r.flush               = fl;
    return r;
  endfunction

  function automatic rtrf_out_t pair(input logic [DATA_W-1:0] v1, input int t1,
                                     input bit b1, input logic [DATA_W-1:0] v2,
                                     input int t2, input bit b2);
    rtrf_rd_t a;
    rtrf_rd_t b;
    a = '{value: v1, tag: TAG_W'(t1), tag_valid: b1};
    b = '{value: v2, tag: TAG_W'(t2), tag_valid: b2};
    return rtrf_out_t'({a, b});
  endfunction

  function automatic void add_row(input rtrf_in_t req, input bit pinned,
                                  input rtrf_out_t res);
    dir_row_t row;
    row.req    = req;
    row.pinned = pinned;
    row.res    = res;
    dir_table.push_back(row);
  endfunction

  // Pick a source: mostly live registers, often one waiting on a rename
  function automatic logic [IDX_W-1:0] pick_source();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12)
      return IDX_W'($urandom_range(31));
    if (roll < 60 && open_renames.size() != 0)
      return open_renames[$urandom_range(open_renames.size() - 1)].dest;
    return IDX_W'($urandom_range(REG_COUNT - 1));
  endfunction

  // Build a request that mostly retires the oldest rename and claims a new one
  function automatic rtrf_in_t next_random_request();
    rtrf_in_t r;
    rename_t  ren;
    int       roll;
    r = '0;
    r.first_source_index  = pick_source();
    r.second_source_index = pick_source();
    r.commit_value        = {$urandom, $urandom};
    r.commit_rob_tag      = TAG_W'($urandom_range(31));
    r.commit_dest_index   = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(REG_COUNT - 1))
                                                      : IDX_W'($urandom_range(31));
    r.issue_rob_tag       = TAG_W'($urandom_range(31));
    r.issue_dest_index    = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(REG_COUNT - 1))
                                                      : IDX_W'($urandom_range(31));
    r.flush               = ($urandom_range(99) < 3);
    // retire in order, with stray and stale commits mixed in
    roll = $urandom_range(99);
    if (roll < 55 && open_renames.size() != 0) begin
      ren = open_renames.pop_front();
      r.commit_write      = 1'b1;
      r.commit_dest_index = ren.dest;
      r.commit_rob_tag    = ren.tag;
    end else begin
      r.commit_write = (roll < 75);
    end
    // claim a destination, sometimes the one being committed
    if ($urandom_range(99) < 55) begin
      r.issue_tag_write = 1'b1;
      if ($urandom_range(99) < 10) r.issue_dest_index = r.commit_dest_index;
      if (open_renames.size() < MAX_OPEN_RENAMES) begin
        ren.dest = r.issue_dest_index;
        ren.tag  = r.issue_rob_tag;
        open_renames.push_back(ren);
      end
    end
    if (r.flush) open_renames.delete();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Offer one request, then record what it should read back
  task automatic offer_request(input rtrf_in_t req, input bit pinned,
                               input rtrf_out_t pinned_res);
    rtrf_out_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = advance_status_table(req);
    expected_reads.push_back(pinned ? pinned_res : predicted);
  endtask

  // Hold the sender until every request has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus long hold-offs on demand
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_done_cnt) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done_cnt++;
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each returned read with the oldest pending one
  always @(posedge clk) begin : check_reads
    rtrf_out_t got;
    rtrf_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_reads.size() == 0) begin
        report_mismatch("result with no request pending", got.first_value, '0);
      end else begin
        want = expected_reads.pop_front();
        if (got.first_value !== want.first_value)
          report_mismatch("first_value", got.first_value, want.first_value);
        if (got.first_tag !== want.first_tag)
          report_mismatch("first_tag", DATA_W'(got.first_tag), DATA_W'(want.first_tag));
        if (got.first_tag_valid !== want.first_tag_valid)
          report_mismatch("first_tag_valid", DATA_W'(got.first_tag_valid),
                          DATA_W'(want.first_tag_valid));
        if (got.second_value !== want.second_value)
          report_mismatch("second_value", got.second_value, want.second_value);
        if (got.second_tag !== want.second_tag)
          report_mismatch("second_tag", DATA_W'(got.second_tag), DATA_W'(want.second_tag));
        if (got.second_tag_valid !== want.second_tag_valid)
          report_mismatch("second_tag_valid", DATA_W'(got.second_tag_valid),
                          DATA_W'(want.second_tag_valid));
      end
    end
  end

  // Give up if the run stalls
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int        src_plan  [4];
    int        sink_plan [4];
    rtrf_out_t zero_res;
    logic [DATA_W-1:0] ones;
    src_plan  = '{0, 78, 0, 23};
    sink_plan = '{0, 0, 78, 23};
    zero_res  = '0;
    ones      = '1;
    foreach (shadow_value[i]) begin
      shadow_value[i] = '0;
      shadow_tag[i]   = '0;
      shadow_busy[i]  = 1'b0;
    end
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    rst_n         = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset contents, range edges, stale commits, flush
    add_row(mk_req(0, 15, 0, 0, 0, 0, 0, '0, 0, 0), 1, zero_res);
    add_row(mk_req(16, 31, 1, 20, 5, 1, 31, ones, 0, 0), 1, zero_res);
    add_row(mk_req(0, 1, 0, 0, 0, 1, 0, ones, 31, 0), 1, zero_res);
    add_row(mk_req(0, 16, 1, 3, 31, 1, 15, 64'h8000_0000_0000_0001, 0, 0), 1,
            pair(ones, 0, 0, '0, 0, 0));
    add_row(mk_req(3, 15, 1, 2, 0, 0, 0, '0, 0, 0), 1,
            pair('0, 31, 1, 64'h8000_0000_0000_0001, 0, 0));
    add_row(mk_req(2, 3, 0, 0, 0, 1, 3, 64'h5555_5555_5555_5555, 30, 0), 1,
            pair('0, 0, 1, '0, 31, 1));
    add_row(mk_req(3, 3, 0, 0, 0, 1, 3, 64'hAAAA_AAAA_AAAA_AAAA, 31, 0), 1,
            pair('0, 31, 1, '0, 31, 1));
    add_row(mk_req(3, 0, 1, 5, 7, 1, 5, 64'd7, 0, 0), 0, zero_res);
    add_row(mk_req(5, 2, 0, 0, 0, 1, 2, 64'd1, 0, 0), 0, zero_res);
    add_row(mk_req(2, 5, 1, 0, 9, 1, 0, '0, 0, 1), 0, zero_res);
    add_row(mk_req(5, 0, 0, 0, 0, 0, 0, '0, 0, 0), 0, zero_res);
    add_row(mk_req(15, 14, 1, 15, 31, 1, 15, 64'h1234, 31, 0), 0, zero_res);
    add_row(mk_req(15, 14, 1, 14, 16, 1, 15, '0, 31, 0), 0, zero_res);
    add_row(mk_req(15, 14, 1, 15, 1, 1, 14, ones, 31, 0), 0, zero_res);
    add_row(mk_req(31, 17, 1, 13, 0, 1, 15, ones, 1, 0), 0, zero_res);
    add_row(mk_req(15, 13, 0, 0, 0, 1, 14, 64'hFEDC, 16, 0), 0, zero_res);
    add_row(mk_req(14, 13, 1, 31, 31, 1, 20, ones, 31, 1), 0, zero_res);
    add_row(mk_req(14, 13, 0, 0, 0, 0, 0, '0, 0, 0), 0, zero_res);
    add_row(mk_req(15, 0, 0, 0, 0, 0, 0, '0, 0, 0), 0, zero_res);

    foreach (dir_table[i])
      offer_request(dir_table[i].req, dir_table[i].pinned, dir_table[i].res);
    wait_drained();

    // Random phases, each drained before the next
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_plan[p];
      sink_stall_pct = sink_plan[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // back up the block while requests keep coming
        if (p == 0 && n == 60) hold_req_cnt++;
        offer_request(next_random_request(), 1'b0, zero_res);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_reads.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
